// ===== rtl/core/gcd_pkg.sv =====
// Package for the great circle distance block: datapath widths and
// elaboration-time CORDIC constants. Depends on nothing.
`default_nettype none
package gcd_pkg;

  // Width of the CORDIC x and y words (Q30 with headroom).
  localparam int XW = 34;
  // Width of the angle accumulator.
  localparam int ZW = 36;
  // Width of the square root remainder and root words.
  localparam int NW = 62;
  // The root of a Q60 value up to one needs 31 result bits.
  localparam int SQRT_STEPS = 31;
  // 1/K in Q30.
  localparam logic signed [XW-1:0] INV_GAIN = XW'(652032874);
  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [33:0] DIST_MAX = 34'h3FFFFFFFF;

  typedef logic signed [XW-1:0] xy_t;
  typedef logic signed [ZW-1:0] ang_t;

  // Quotient by shift and subtract; only called on constants.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) from its series in Q62, rounded to f fraction bits.
  function automatic longint atan_qf(input int i, input int f);
    longint unsigned sum;
    longint unsigned term;
    int k;
    int sh;
    sum = 0;
    if (i == 0) begin
      sum = PI_Q60;
    end else begin
      for (k = 0; 62 - (2 * k + 1) * i >= 0; k++) begin
        sh = 62 - (2 * k + 1) * i;
        term = udiv64(64'd1 << sh, longint'(2 * k + 1));
        if (k[0]) sum = sum - term;
        else sum = sum + term;
      end
    end
    return longint'((sum + (64'd1 << (61 - f))) >> (62 - f));
  endfunction

  function automatic longint pi_qf(input int f);
    return longint'((PI_Q60 + (64'd1 << (59 - f))) >> (60 - f));
  endfunction

  function automatic longint half_pi_qf(input int f);
    return longint'((PI_Q60 + (64'd1 << (60 - f))) >> (61 - f));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gcd_rot_cell.sv =====
// One rotation-mode CORDIC iteration with its output register.
// Depends on gcd_pkg.
`default_nettype none
module gcd_rot_cell #(
  parameter int I = 0,
  parameter int F = 29
) (
  input  wire                   clk_i,
  input  wire gcd_pkg::xy_t     x_i,
  input  wire gcd_pkg::xy_t     y_i,
  input  wire gcd_pkg::ang_t    z_i,
  input  wire                   neg_i,
  output gcd_pkg::xy_t          x_o,
  output gcd_pkg::ang_t         z_o,
  output gcd_pkg::xy_t          y_o,
  output logic                  neg_o
);
  localparam gcd_pkg::ang_t AT = gcd_pkg::ZW'(gcd_pkg::atan_qf(I, F));

  gcd_pkg::xy_t x_d, y_d;
  gcd_pkg::ang_t z_d;

  always_comb begin
    if (z_i >= 0) begin
      x_d = x_i - (y_i >>> I);
      y_d = y_i + (x_i >>> I);
      z_d = z_i - AT;
    end else begin
      x_d = x_i + (y_i >>> I);
      y_d = y_i - (x_i >>> I);
      z_d = z_i + AT;
    end
  end

  always_ff @(posedge clk_i) begin
    x_o   <= x_d;
    y_o   <= y_d;
    z_o   <= z_d;
    neg_o <= neg_i;
  end
endmodule
`default_nettype wire

// ===== rtl/core/gcd_sqrt_cell.sv =====
// One bit of a restoring integer square root with its output register.
// Depends on gcd_pkg.
`default_nettype none
module gcd_sqrt_cell #(
  parameter int J = 0
) (
  input  wire                      clk_i,
  input  wire [gcd_pkg::NW-1:0]    n_i,
  input  wire [gcd_pkg::NW-1:0]    r_i,
  output logic [gcd_pkg::NW-1:0]   n_o,
  output logic [gcd_pkg::NW-1:0]   r_o
);
  localparam logic [gcd_pkg::NW:0] BIT =
    (gcd_pkg::NW+1)'(1) << (2 * (gcd_pkg::SQRT_STEPS - 1 - J));

  logic [gcd_pkg::NW:0] trial;
  logic [gcd_pkg::NW-1:0] n_d, r_d;

  always_comb begin
    trial = {1'b0, r_i} + BIT;
    if ({1'b0, n_i} >= trial) begin
      n_d = gcd_pkg::NW'({1'b0, n_i} - trial);
      r_d = gcd_pkg::NW'({1'b0, r_i >> 1} + BIT);
    end else begin
      n_d = n_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    n_o <= n_d;
    r_o <= r_d;
  end
endmodule
`default_nettype wire

// ===== rtl/core/gcd_vec_cell.sv =====
// One vectoring-mode CORDIC iteration with its output register.
// Depends on gcd_pkg.
`default_nettype none
module gcd_vec_cell #(
  parameter int I = 0,
  parameter int F = 29
) (
  input  wire                   clk_i,
  input  wire gcd_pkg::xy_t     x_i,
  input  wire gcd_pkg::xy_t     y_i,
  input  wire gcd_pkg::ang_t    z_i,
  output gcd_pkg::xy_t          x_o,
  output gcd_pkg::xy_t          y_o,
  output gcd_pkg::ang_t         z_o
);
  localparam gcd_pkg::ang_t AT = gcd_pkg::ZW'(gcd_pkg::atan_qf(I, F));

  gcd_pkg::xy_t x_d, y_d;
  gcd_pkg::ang_t z_d;

  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + (y_i >>> I);
      y_d = y_i - (x_i >>> I);
      z_d = z_i + AT;
    end else begin
      x_d = x_i - (y_i >>> I);
      y_d = y_i + (x_i >>> I);
      z_d = z_i - AT;
    end
  end

  always_ff @(posedge clk_i) begin
    x_o <= x_d;
    y_o <= y_d;
    z_o <= z_d;
  end
endmodule
`default_nettype wire

// ===== rtl/core/great_circle_distance_top.sv =====
// Haversine great circle distance, fully pipelined chain of CORDIC and root cells.
// Depends on gcd_pkg, gcd_rot_cell, gcd_sqrt_cell and gcd_vec_cell.
// Throughput: one item per cycle; busy_o is always low and results cannot be held off.
// Reset clears the valid pipeline and loads the radius with 6371000; no clearing pass.
`default_nettype none
module great_circle_distance_top #(
  parameter int CORDIC_STEPS    = 28,
  parameter int ANGLE_FRAC_BITS = 29
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  output logic              busy_o,
  input  wire signed [30:0] lat_a_i,
  input  wire signed [31:0] lon_a_i,
  input  wire signed [30:0] lat_b_i,
  input  wire signed [31:0] lon_b_i,
  input  wire               radius_we_i,
  input  wire [23:0]        radius_i,
  output logic              done_o,
  output logic [33:0]       distance_o
);
  localparam int CS = CORDIC_STEPS;
  localparam int F  = ANGLE_FRAC_BITS;
  localparam int LATENCY = 1 + CS + 1 + 3 + gcd_pkg::SQRT_STEPS + CS + 3;
  localparam gcd_pkg::ang_t PI_F    = gcd_pkg::ZW'(gcd_pkg::pi_qf(F));
  localparam gcd_pkg::ang_t HALF_PI = gcd_pkg::ZW'(gcd_pkg::half_pi_qf(F));
  localparam gcd_pkg::xy_t  Q_ONE   = gcd_pkg::XW'(64'd1 << 30);
  localparam int NW = gcd_pkg::NW;

  // The block never stalls: every cycle a new item may enter the chain.
  assign busy_o = 1'b0;

  // Radius register. The user must let writes happen only while the pipeline is empty;
  // the block does not enforce this. The output stage reads it directly.
  logic [23:0] radius_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 24'd6371000;
    end else if (radius_we_i) begin
      radius_q <= radius_i;
    end
  end

  // Valid bit travels alongside the data through every stage.
  logic [LATENCY-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start_i & ~busy_o};
    end
  end
  assign done_o = vld_q[LATENCY-1];

  // Angle preparation. The four angles are the half latitude difference, the
  // half longitude difference and both latitudes. The differences are taken
  // exactly in Q29 before the shift that halves them and moves them to QF.
  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  gcd_pkg::ang_t th [4];
  gcd_pkg::ang_t z0_d [4];
  logic [3:0] neg0_d;

  assign dlat = 32'(lat_b_i) - 32'(lat_a_i);
  assign dlon = 33'(lon_b_i) - 33'(lon_a_i);

  always_comb begin
    th[0] = gcd_pkg::ZW'(dlat >>> (30 - F));
    th[1] = gcd_pkg::ZW'(dlon >>> (30 - F));
    th[2] = gcd_pkg::ZW'(lat_a_i >>> (29 - F));
    th[3] = gcd_pkg::ZW'(lat_b_i >>> (29 - F));
    for (int k = 0; k < 4; k++) begin
      // Angles past a quarter turn are folded by half a turn, which flips
      // the sign of both sine and cosine.
      if (th[k] > HALF_PI) begin
        z0_d[k]   = th[k] - PI_F;
        neg0_d[k] = 1'b1;
      end else if (th[k] < -HALF_PI) begin
        z0_d[k]   = th[k] + PI_F;
        neg0_d[k] = 1'b1;
      end else begin
        z0_d[k]   = th[k];
        neg0_d[k] = 1'b0;
      end
    end
  end

  gcd_pkg::xy_t  rx [4][CS+1];
  gcd_pkg::xy_t  ry [4][CS+1];
  gcd_pkg::ang_t rz [4][CS+1];
  logic          rn [4][CS+1];

  // Four rows of rotation cells run side by side, one iteration per cell.
  for (genvar g = 0; g < 4; g++) begin : g_rot_row
    always_ff @(posedge clk_i) begin
      rx[g][0] <= gcd_pkg::INV_GAIN;
      ry[g][0] <= '0;
      rz[g][0] <= z0_d[g];
      rn[g][0] <= neg0_d[g];
    end

    for (genvar j = 0; j < CS; j++) begin : g_rot
      gcd_rot_cell #(.I(j), .F(F)) u_cell (
        .clk_i (clk_i),
        .x_i   (rx[g][j]),
        .y_i   (ry[g][j]),
        .z_i   (rz[g][j]),
        .neg_i (rn[g][j]),
        .x_o   (rx[g][j+1]),
        .y_o   (ry[g][j+1]),
        .z_o   (rz[g][j+1]),
        .neg_o (rn[g][j+1])
      );
    end
  end

  function automatic gcd_pkg::xy_t clamp_one(input gcd_pkg::xy_t v);
    if (v > Q_ONE) return Q_ONE;
    if (v < -Q_ONE) return -Q_ONE;
    return v;
  endfunction

  // Clamp to [-1,1] and undo the fold. Rows 0 and 1 give sines, rows 2 and 3
  // give cosines.
  logic signed [31:0] trig_q [4];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (k < 2) begin
        trig_q[k] <= 32'(rn[k][CS] ? -clamp_one(ry[k][CS]) : clamp_one(ry[k][CS]));
      end else begin
        trig_q[k] <= 32'(rn[k][CS] ? -clamp_one(rx[k][CS]) : clamp_one(rx[k][CS]));
      end
    end
  end

  // Q30 products, rounded half up.
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return 32'(p >>> 30);
  endfunction

  logic signed [31:0] s1sq_q, s2sq_q, cacb_q, s1sq2_q, term_q;
  always_ff @(posedge clk_i) begin
    s1sq_q  <= mulq(trig_q[0], trig_q[0]);
    s2sq_q  <= mulq(trig_q[1], trig_q[1]);
    cacb_q  <= mulq(trig_q[2], trig_q[3]);
    s1sq2_q <= s1sq_q;
    term_q  <= mulq(cacb_q, s2sq_q);
  end

  // Haversine term clamped to [0,1], then both root arguments in Q60.
  logic signed [32:0] a_sum;
  logic [30:0] a_c;
  assign a_sum = 33'(s1sq2_q) + 33'(term_q);
  always_comb begin
    if (a_sum < 0) a_c = '0;
    else if (a_sum > 33'sd1073741824) a_c = 31'd1073741824;
    else a_c = a_sum[30:0];
  end

  logic [NW-1:0] n1 [gcd_pkg::SQRT_STEPS+1];
  logic [NW-1:0] r1 [gcd_pkg::SQRT_STEPS+1];
  logic [NW-1:0] n0 [gcd_pkg::SQRT_STEPS+1];
  logic [NW-1:0] r0 [gcd_pkg::SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    n1[0] <= NW'({a_c, 30'd0});
    n0[0] <= NW'({31'd1073741824 - a_c, 30'd0});
    r1[0] <= '0;
    r0[0] <= '0;
  end

  // Two rows of root cells, one result bit per cell.
  for (genvar j = 0; j < gcd_pkg::SQRT_STEPS; j++) begin : g_sqrt
    gcd_sqrt_cell #(.J(j)) u_sq1 (
      .clk_i (clk_i),
      .n_i   (n1[j]),
      .r_i   (r1[j]),
      .n_o   (n1[j+1]),
      .r_o   (r1[j+1])
    );
    gcd_sqrt_cell #(.J(j)) u_sq0 (
      .clk_i (clk_i),
      .n_i   (n0[j]),
      .r_i   (r0[j]),
      .n_o   (n0[j+1]),
      .r_o   (r0[j+1])
    );
  end

  // Vectoring row: the angle of (sqrt(1-a), sqrt(a)).
  gcd_pkg::xy_t  vx [CS+1];
  gcd_pkg::xy_t  vy [CS+1];
  gcd_pkg::ang_t vz [CS+1];
  assign vx[0] = gcd_pkg::XW'(r0[gcd_pkg::SQRT_STEPS][30:0]);
  assign vy[0] = gcd_pkg::XW'(r1[gcd_pkg::SQRT_STEPS][30:0]);
  assign vz[0] = '0;

  for (genvar j = 0; j < CS; j++) begin : g_vec
    gcd_vec_cell #(.I(j), .F(F)) u_cell (
      .clk_i (clk_i),
      .x_i   (vx[j]),
      .y_i   (vy[j]),
      .z_i   (vz[j]),
      .x_o   (vx[j+1]),
      .y_o   (vy[j+1]),
      .z_o   (vz[j+1])
    );
  end

  // Radius times twice the angle, split into two narrow partial products.
  logic [33:0] two_ang;
  assign two_ang = (vz[CS] < 0) ? 34'd0 : {vz[CS][32:0], 1'b0};

  logic [40:0] p_lo_q, p_hi_q;
  logic [57:0] prod_q;
  logic [58:0] prod_rnd;
  logic [58:0] scaled;
  always_ff @(posedge clk_i) begin
    p_lo_q <= 41'(radius_q) * 41'(two_ang[16:0]);
    p_hi_q <= 41'(radius_q) * 41'(two_ang[33:17]);
    prod_q <= (58'(p_hi_q) << 17) + 58'(p_lo_q);
  end

  assign prod_rnd = 59'(prod_q) + (59'd1 << (F - 9));
  assign scaled   = prod_rnd >> (F - 8);

  always_ff @(posedge clk_i) begin
    distance_o <= (scaled > 59'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : scaled[33:0];
  end
endmodule
`default_nettype wire

// ===== rtl/core/gcd_checker.sv =====
// Port-level checks for the great circle distance block, and their binding.
// Depends on great_circle_distance_top.
`default_nettype none
module gcd_port_checker #(
  parameter int LATENCY = 95
) (
  input wire clk_i,
  input wire rst_ni,
  input wire start_i,
  input wire busy_i,
  input wire done_i
);
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_i)
    else $error("busy raised on a block that never stalls");

  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(start_i, LATENCY))
    else $error("result without a matching item");

  a_item_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |-> ##LATENCY done_i)
    else $error("item produced no result");
endmodule

bind great_circle_distance_top gcd_port_checker #(.LATENCY(LATENCY)) u_gcd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .done_i  (done_o)
);
`default_nettype wire

// ===== sim/gcd_checker.sv =====
// Checker for the great circle distance block: predicts each distance from the
// accepted coordinates and the current radius, then compares it with done_o items.
// Depends on gcd_pkg for the pi constant.
`timescale 1ns / 1ps
module gcd_checker #(
  parameter int CORDIC_STEPS    = 28,
  parameter int ANGLE_FRAC_BITS = 29
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire               busy_i,
  input  wire signed [30:0] lat_a_i,
  input  wire signed [31:0] lon_a_i,
  input  wire signed [30:0] lat_b_i,
  input  wire signed [31:0] lon_b_i,
  input  wire               radius_we_i,
  input  wire [23:0]        radius_i,
  input  wire               done_i,
  input  wire [33:0]        distance_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);

  localparam longint Q30_ONE = 64'sd1 << 30;
  localparam longint INV_GAIN_Q30 = 652032874;
  localparam longint DIST_LIMIT = 64'h3FFFFFFFF;

  longint    arctan_tbl [CORDIC_STEPS];
  logic [23:0] radius_q;
  logic [33:0] dist_queue [$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  initial begin
    longint unsigned sum, term;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      sum = 0;
      if (i == 0) begin
        sum = gcd_pkg::PI_Q60;
      end else begin
        for (int k = 0; 62 - (2 * k + 1) * i >= 0; k++) begin
          term = (64'd1 << (62 - (2 * k + 1) * i)) / longint'(2 * k + 1);
          if (k % 2) sum = sum - term;
          else sum = sum + term;
        end
      end
      arctan_tbl[i] = (longint'(sum) + (64'sd1 << (61 - ANGLE_FRAC_BITS)))
                      >>> (62 - ANGLE_FRAC_BITS);
    end
  end

  task automatic rotate(input longint theta, output longint s, output longint c);
    longint pi_f, half_pi, x, y, z, nx;
    bit flip;
    pi_f = longint'((gcd_pkg::PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS)))
                    >> (60 - ANGLE_FRAC_BITS));
    half_pi = longint'((gcd_pkg::PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS)))
                       >> (61 - ANGLE_FRAC_BITS));
    x = INV_GAIN_Q30;
    y = 0;
    z = theta;
    flip = 0;
    if (z > half_pi) begin
      z = z - pi_f;
      flip = 1;
    end else if (z < -half_pi) begin
      z = z + pi_f;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_tbl[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_tbl[i];
      end
      x = nx;
    end
    x = clip(x, -Q30_ONE, Q30_ONE);
    y = clip(y, -Q30_ONE, Q30_ONE);
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint vector_angle(longint y, longint x);
    longint z, nx;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_tbl[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_tbl[i];
      end
      x = nx;
    end
    return z;
  endfunction

  task automatic predict_distance(input longint la, input longint loa, input longint lb,
                                  input longint lob, output logic [33:0] pred);
    longint s_lat, s_lon, c_a, c_b, unused, hav, root_a, root_b, ang;
    longint unsigned prod;
    rotate(floor_shift(lb - la, 30 - ANGLE_FRAC_BITS), s_lat, unused);
    rotate(floor_shift(lob - loa, 30 - ANGLE_FRAC_BITS), s_lon, unused);
    rotate(floor_shift(la, 29 - ANGLE_FRAC_BITS), unused, c_a);
    rotate(floor_shift(lb, 29 - ANGLE_FRAC_BITS), unused, c_b);
    hav = mul_q30(s_lat, s_lat) + mul_q30(mul_q30(c_a, c_b), mul_q30(s_lon, s_lon));
    hav = clip(hav, 0, Q30_ONE);
    root_a = floor_root(longint'(hav) << 30);
    root_b = floor_root(longint'(Q30_ONE - hav) << 30);
    ang = vector_angle(root_a, root_b);
    if (ang < 0) ang = 0;
    prod = longint'(radius_q) * longint'(2 * ang);
    prod = (prod + (64'd1 << (ANGLE_FRAC_BITS - 9))) >> (ANGLE_FRAC_BITS - 8);
    if (prod > DIST_LIMIT) prod = DIST_LIMIT;
    pred = prod[33:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [33:0] want;
    if (!rst_ni) begin
      radius_q = 24'd6371000;
      dist_queue.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      // A result and a start in the same edge are independent, so order is free.
      if (done_i) begin
        if (dist_queue.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected distance %0d", distance_i);
        end else begin
          want = dist_queue.pop_front();
          checked_o++;
          if (distance_i !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("distance mismatch: expected %0d got %0d", want, distance_i);
          end
        end
      end
      // A radius written at the accepting edge already applies to that item.
      if (radius_we_i) radius_q = radius_i;
      if (start_i && !busy_i) begin
        predict_distance(lat_a_i, lon_a_i, lat_b_i, lon_b_i, want);
        dist_queue.push_back(want);
      end
    end
    pending_o = dist_queue.size();
  end

endmodule

// ===== sim/great_circle_distance_top_tb.sv =====
// Testbench top for the great circle distance block: drives coordinate items
// and radius settings; gcd_checker predicts and compares. Depends on both.
`timescale 1ns / 1ps
module great_circle_distance_top_tb;

  localparam int LATENCY = 95;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint LAT_MAX = 843314857;
  localparam longint LON_MAX = 1686629713;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start_i = 0;
  logic signed [30:0] lat_a_i = '0;
  logic signed [31:0] lon_a_i = '0;
  logic signed [30:0] lat_b_i = '0;
  logic signed [31:0] lon_b_i = '0;
  logic               radius_we_i = 0;
  logic [23:0]        radius_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [33:0]        distance_o;
  int                 fail_count, pending, checked;
  int                 idle_cycles;
  int                 items_sent;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  great_circle_distance_top i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .lat_a_i, .lon_a_i, .lat_b_i, .lon_b_i,
    .radius_we_i, .radius_i, .done_o, .distance_o
  );

  gcd_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .lat_a_i, .lon_a_i, .lat_b_i,
    .lon_b_i, .radius_we_i, .radius_i, .done_i(done_o), .distance_i(distance_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // The watchdog only counts cycles in which neither side moved an item.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || radius_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d distances outstanding", pending);
      $display("great_circle_distance_top_tb: errors");
      $finish;
    end
  end

  // Holds one item on the ports until the block takes it. Start stays high
  // across back-to-back items, so it is only lowered once a gap begins.
  task automatic send_item(input logic [30:0] la, input logic [31:0] loa,
                           input logic [30:0] lb, input logic [31:0] lob);
    start_i <= 1'b1;
    lat_a_i <= la;
    lon_a_i <= loa;
    lat_b_i <= lb;
    lon_b_i <= lob;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // New radius only once the pipe has drained, with latency margin on top.
  task automatic set_radius(input logic [23:0] value);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    radius_we_i <= 1'b1;
    radius_i <= value;
    @(posedge clk_i);
    radius_we_i <= 1'b0;
  endtask

  function automatic longint rand_range(longint lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Mostly in-range coordinates; now and then a raw pattern to toggle every bit,
  // including those outside the stated ranges.
  task automatic send_random;
    logic [30:0] la, lb;
    logic [31:0] loa, lob;
    if ($urandom_range(0, 9) == 0) begin
      la = 31'($urandom);
      lb = 31'($urandom);
      loa = $urandom;
      lob = $urandom;
    end else begin
      la = 31'(rand_range(LAT_MAX));
      lb = 31'(rand_range(LAT_MAX));
      loa = 32'(rand_range(LON_MAX));
      lob = 32'(rand_range(LON_MAX));
      // Near-identical and antipodal pairs stress the clamp on the haversine term.
      case ($urandom_range(0, 5))
        0: begin
          lb = la + 31'($urandom_range(0, 7)) - 31'sd3;
          lob = loa + 32'($urandom_range(0, 7)) - 32'sd3;
        end
        1: begin
          lb = -la;
          lob = ($signed(loa) > 0) ? loa - 32'(1686629713) : loa + 32'(1686629713);
        end
        default: ;
      endcase
    end
    send_item(la, loa, lb, lob);
  endtask

  task automatic directed_items;
    send_item('0, '0, '0, '0);
    send_item(31'(LAT_MAX), 32'(LON_MAX), 31'(-LAT_MAX), 32'(-LON_MAX));
    send_item(31'(-LAT_MAX), 32'(-LON_MAX), 31'(LAT_MAX), 32'(LON_MAX));
    send_item(31'(LAT_MAX), '0, 31'(LAT_MAX), 32'(LON_MAX));
    send_item('0, 32'(-LON_MAX), '0, 32'(LON_MAX));
    send_item('0, '0, '0, 32'(LON_MAX));
    send_item(31'(LAT_MAX), '0, 31'(-LAT_MAX), '0);
    send_item(31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000);
    send_item(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF);
    send_item(31'h7FFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
    send_item(31'd1000, 32'd2000, 31'd1001, 32'd2001);
    send_item(31'd421657428, 32'd843314857, 31'd421657428, 32'd843314857);
    pause(3);
  endtask

  initial begin
    logic [23:0] radii [5];
    int burst;
    radii = '{24'd6371000, 24'd1, 24'hFFFFFF, 24'd0, 24'd1000};
    idle_cycles = 0;
    items_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset radius is checked first, then the rest including the largest
    // and a zero radius.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase != 0) set_radius(radii[phase]);
      directed_items();
      for (int n = 0; n < 100; ) begin
        burst = $urandom_range(1, 30);
        for (int k = 0; k < burst && n < 100; k++, n++) send_random();
        pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
      end
    end
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);

    $display("sent %0d coordinate items over five radius settings, checked %0d distances",
             items_sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("great_circle_distance_top_tb: clean");
    end else begin
      $display("great_circle_distance_top_tb: errors");
    end
    $finish;
  end

endmodule
